// ===== rtl/phcal_pkg.sv =====
// ----------------------------------------------------------------------------
// phcal_pkg
// Shared constants, widths and types for the pH calibration block.
// ----------------------------------------------------------------------------
package phcal_pkg;

  localparam int SAMPLES_PER_READING = 10;
  localparam int ADC_BITS            = 10;

  localparam int CAL_W = 10;
  localparam int LIM_W = 11;
  localparam int PH_W  = 11;

  localparam int PH_MID  = 700;
  localparam int PH_SPAN = 300;
  localparam int PH_MAX  = 1400;

  localparam int SUM_MAX = (2**ADC_BITS - 1) * SAMPLES_PER_READING;
  localparam int SUM_W   = $clog2(SUM_MAX + 1);
  localparam int IDX_W   = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
  localparam int REF_MAX = (2**CAL_W - 1) * SAMPLES_PER_READING;
  localparam int REF_W   = $clog2(REF_MAX + 1);
  localparam int DIFF_W  = (SUM_W > REF_W) ? SUM_W : REF_W;
  localparam int NUM_MAX = (2**DIFF_W - 1) * PH_SPAN;
  localparam int DVD_W   = $clog2(2 * NUM_MAX + REF_MAX + 1);
  localparam int DSR_W   = REF_W + 1;
  localparam int CNT_W   = $clog2(DVD_W + 1);

  localparam int NUM_REGS  = 5;
  localparam int ADDR_W    = $clog2(NUM_REGS * 4);
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam int DATA_W    = 32;

  localparam logic [REG_IDX_W-1:0] REG_CAL4   = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_CAL7   = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_CAL10  = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_HI_LIM = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_LO_LIM = REG_IDX_W'(4);

  typedef struct packed {
    logic [CAL_W-1:0] cal4;
    logic [CAL_W-1:0] cal7;
    logic [CAL_W-1:0] cal10;
    logic [LIM_W-1:0] hi_lim;
    logic [LIM_W-1:0] lo_lim;
  } phcal_cfg_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] sum;
  } grp_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/phcal_if.sv =====
// ----------------------------------------------------------------------------
// phcal_if
// Valid/ready stream interfaces for ADC samples and pH results.
// ----------------------------------------------------------------------------
interface phcal_in_if import phcal_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface phcal_out_if import phcal_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PH_W-1:0] ph_hundredths;
  logic            ionizer_on;

  modport source (output valid, output ph_hundredths, output ionizer_on, input ready);
  modport sink   (input valid, input ph_hundredths, input ionizer_on, output ready);
endinterface

// ===== rtl/phcal_regs.sv =====
// ----------------------------------------------------------------------------
// phcal_regs
// APB-style register file for calibration points and relay limits.
// ----------------------------------------------------------------------------
module phcal_regs import phcal_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output phcal_cfg_t        cfg
);

  phcal_cfg_t             cfg_r;
  phcal_cfg_t             cfg_nxt;
  logic                   wr_en;
  logic [REG_IDX_W-1:0]   idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[ADDR_W-1:2];
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_CAL4:   cfg_nxt.cal4   = pwdata[CAL_W-1:0];
        REG_CAL7:   cfg_nxt.cal7   = pwdata[CAL_W-1:0];
        REG_CAL10:  cfg_nxt.cal10  = pwdata[CAL_W-1:0];
        REG_HI_LIM: cfg_nxt.hi_lim = pwdata[LIM_W-1:0];
        REG_LO_LIM: cfg_nxt.lo_lim = pwdata[LIM_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CAL4:   prdata = DATA_W'(cfg_r.cal4);
      REG_CAL7:   prdata = DATA_W'(cfg_r.cal7);
      REG_CAL10:  prdata = DATA_W'(cfg_r.cal10);
      REG_HI_LIM: prdata = DATA_W'(cfg_r.hi_lim);
      REG_LO_LIM: prdata = DATA_W'(cfg_r.lo_lim);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cal4   <= CAL_W'(358);
      cfg_r.cal7   <= CAL_W'(522);
      cfg_r.cal10  <= CAL_W'(666);
      cfg_r.hi_lim <= LIM_W'(760);
      cfg_r.lo_lim <= LIM_W'(720);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/phcal_accum.sv =====
// ----------------------------------------------------------------------------
// phcal_accum
// Group accumulator: sums samples and flags the last one of each group.
// ----------------------------------------------------------------------------
module phcal_accum import phcal_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  logic [ADC_BITS-1:0] sample,
  output grp_t                grp
);

  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic [SUM_W-1:0] total;
  logic             last;

  assign total     = sum_r + SUM_W'(sample);
  assign last      = (idx_r == IDX_W'(SAMPLES_PER_READING - 1));
  assign grp.start = take && last;
  assign grp.sum   = total;

  always_comb begin
    sum_nxt = sum_r;
    idx_nxt = idx_r;
    if (take) begin
      if (last) begin
        sum_nxt = '0;
        idx_nxt = '0;
      end else begin
        sum_nxt = total;
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      idx_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      idx_r <= idx_nxt;
    end
  end

endmodule

// ===== rtl/phcal_div.sv =====
// ----------------------------------------------------------------------------
// phcal_div
// Restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module phcal_div import phcal_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic             busy_r,  busy_nxt;
  logic             done_r,  done_nxt;
  logic [CNT_W-1:0] cnt_r,   cnt_nxt;
  logic [DVD_W-1:0] dq_r,    dq_nxt;
  logic [DSR_W-1:0] rem_r,   rem_nxt;
  logic [DSR_W-1:0] dsr_r,   dsr_nxt;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             ge;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem_r, dq_r[DVD_W-1]};
  assign ge    = (trial >= {1'b0, dsr_r});
  assign diff  = trial - {1'b0, dsr_r};

  assign rsp.done     = done_r;
  assign rsp.quotient = dq_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DVD_W);
      dq_nxt   = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      dq_nxt  = {dq_r[DVD_W-2:0], ge};
      rem_nxt = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

endmodule

// ===== rtl/phcal_conv.sv =====
// ----------------------------------------------------------------------------
// phcal_conv
// Group sum to pH sequencer: operand setup, divide, clamp, relay, output.
// ----------------------------------------------------------------------------
module phcal_conv import phcal_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  phcal_cfg_t cfg,
  input  grp_t       grp,
  output logic       busy,
  output div_req_t   div_req,
  input  div_rsp_t   div_rsp,
  phcal_out_if.source out_ch
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_REF    = 7'b0000010,
    S_SIDE   = 7'b0000100,
    S_NUM    = 7'b0001000,
    S_LAUNCH = 7'b0010000,
    S_DIV    = 7'b0100000,
    S_DONE   = 7'b1000000
  } conv_state_t;

  conv_state_t      state_r, state_nxt;
  logic [SUM_W-1:0] sum_r;
  logic [REF_W-1:0] ref_r;
  logic [CAL_W-1:0] ad_lo_r, ad_hi_r;
  logic             neg_lo_r, neg_hi_r;
  logic             lower_r;
  logic [DIFF_W-1:0] diff_r;
  logic [REF_W-1:0] den_r;
  logic             den_neg_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DSR_W-1:0] dsr_r;
  logic             den_zero_r;
  logic             out_valid_r;
  logic [PH_W-1:0]  ph_r;
  logic             relay_r;

  logic [DIFF_W-1:0] s_ext, ref_ext;
  logic              minus;
  logic              q_over;
  logic [PH_W-1:0]   ph_val;
  logic              relay_val;
  logic              slot_free;

  assign busy      = (state_r != S_IDLE);
  assign slot_free = !out_valid_r || out_ch.ready;
  assign s_ext     = DIFF_W'(sum_r);
  assign ref_ext   = DIFF_W'(ref_r);

  assign div_req.start    = (state_r == S_LAUNCH);
  assign div_req.dividend = dvd_r;
  assign div_req.divisor  = dsr_r;

  // sign of the step away from pH 7 flips with a reversed calibration
  assign minus  = lower_r ^ den_neg_r;
  assign q_over = (div_rsp.quotient > DVD_W'(PH_MID));

  always_comb begin
    if (den_zero_r) begin
      if (lower_r) begin
        ph_val = (diff_r == '0) ? PH_W'(PH_MID) : '0;
      end else begin
        ph_val = PH_W'(PH_MAX);
      end
    end else if (minus) begin
      ph_val = q_over ? '0 : PH_W'(PH_MID) - PH_W'(div_rsp.quotient);
    end else begin
      ph_val = q_over ? PH_W'(PH_MAX) : PH_W'(PH_MID) + PH_W'(div_rsp.quotient);
    end
  end

  always_comb begin
    priority if (ph_val > cfg.hi_lim) begin
      relay_val = 1'b0;
    end else if (ph_val < cfg.lo_lim) begin
      relay_val = 1'b1;
    end else begin
      relay_val = relay_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (grp.start) state_nxt = S_REF;
      S_REF:    state_nxt = S_SIDE;
      S_SIDE:   state_nxt = S_NUM;
      // skip the divider when the slope on this side is flat
      S_NUM:    state_nxt = (den_r == '0) ? S_DONE : S_LAUNCH;
      S_LAUNCH: state_nxt = S_DIV;
      S_DIV:    if (div_rsp.done) state_nxt = S_DONE;
      S_DONE:   if (slot_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      relay_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && slot_free) begin
        out_valid_r <= 1'b1;
        relay_r     <= relay_val;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && grp.start) begin
      sum_r <= grp.sum;
    end
    if (state_r == S_REF) begin
      ref_r    <= REF_W'(cfg.cal7) * REF_W'(SAMPLES_PER_READING);
      neg_lo_r <= (cfg.cal7 < cfg.cal4);
      ad_lo_r  <= (cfg.cal7 < cfg.cal4) ? cfg.cal4 - cfg.cal7 : cfg.cal7 - cfg.cal4;
      neg_hi_r <= (cfg.cal10 < cfg.cal7);
      ad_hi_r  <= (cfg.cal10 < cfg.cal7) ? cfg.cal7 - cfg.cal10 : cfg.cal10 - cfg.cal7;
    end
    if (state_r == S_SIDE) begin
      lower_r   <= (s_ext <= ref_ext);
      diff_r    <= (s_ext <= ref_ext) ? ref_ext - s_ext : s_ext - ref_ext;
      den_r     <= REF_W'((s_ext <= ref_ext) ? ad_lo_r : ad_hi_r)
                   * REF_W'(SAMPLES_PER_READING);
      den_neg_r <= (s_ext <= ref_ext) ? neg_lo_r : neg_hi_r;
    end
    if (state_r == S_NUM) begin
      // round to nearest: (2*num + den) / (2*den)
      dvd_r      <= DVD_W'(diff_r) * DVD_W'(2 * PH_SPAN) + DVD_W'(den_r);
      dsr_r      <= {den_r, 1'b0};
      den_zero_r <= (den_r == '0);
    end
    if (state_r == S_DONE && slot_free) begin
      ph_r <= ph_val;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.ph_hundredths = ph_r;
  assign out_ch.ionizer_on    = relay_r;

endmodule

// ===== rtl/ph_average_calibrate_hysteresis_top.sv =====
// ----------------------------------------------------------------------------
// ph_average_calibrate_hysteresis_top
// Averages ADC samples per group, converts to pH via three-point
// calibration and drives a hysteresis relay flag.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Transfer unit                    Handshake
//  -------  ---------  -------------------------------  -------------------
//  in_ch    sink       adc_sample                       valid && ready
//  out_ch   source     ph_hundredths, ionizer_on        valid && ready
//  cfg      APB write  cal points, relay limits         psel&penable&pwrite
//
//  Samples that do not close a group are taken one per cycle while no
//  conversion runs. The transfer that closes a group starts a conversion
//  that holds in_ch ready low through operand setup, the serial divider
//  (one quotient bit per cycle) and the output step. A flat slope on
//  the selected side skips the divider. A result waiting in the output
//  register does not hold off new samples; only a finished conversion
//  stalls until the output register frees up. Reset is synchronous,
//  active low: sums, counters and relay clear, the calibration
//  registers load their defaults.
//
module ph_average_calibrate_hysteresis_top import phcal_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  phcal_in_if.sink          in_ch,
  phcal_out_if.source       out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  phcal_cfg_t cfg;
  grp_t       grp;
  div_req_t   div_req;
  div_rsp_t   div_rsp;
  logic       conv_busy;
  logic       take;

  // hold off samples only while a group is being converted
  assign in_ch.ready = !conv_busy;
  assign take        = in_ch.valid && in_ch.ready;

  phcal_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // advance the group sum on every sample transfer
  phcal_accum u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .sample (in_ch.adc_sample),
    .grp    (grp)
  );

  phcal_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  phcal_conv u_conv (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .grp     (grp),
    .busy    (conv_busy),
    .div_req (div_req),
    .div_rsp (div_rsp),
    .out_ch  (out_ch)
  );

endmodule

// ===== tb/phcal_checker.sv =====
// ----------------------------------------------------------------------------
// phcal_checker
// Watches the sample, result and register ports of the pH block, predicts
// every reading from its own copy of the calibration and group state, and
// compares each delivered reading against the oldest prediction.
// ----------------------------------------------------------------------------
module phcal_checker import phcal_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [ADC_BITS-1:0] in_sample,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [PH_W-1:0]     out_ph,
  input  logic                out_ion,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CAL_W-1:0] CAL4_RST   = CAL_W'(358);
  localparam logic [CAL_W-1:0] CAL7_RST   = CAL_W'(522);
  localparam logic [CAL_W-1:0] CAL10_RST  = CAL_W'(666);
  localparam logic [LIM_W-1:0] HI_LIM_RST = LIM_W'(760);
  localparam logic [LIM_W-1:0] LO_LIM_RST = LIM_W'(720);

  typedef struct packed {
    logic [PH_W-1:0] ph;
    logic            ion;
  } reading_t;

  phcal_cfg_t       cal;
  logic [SUM_W-1:0] group_sum;
  logic [IDX_W-1:0] group_cnt;
  logic             relay;
  reading_t         reading_q[$];
  int               n_fail = 0;

  task automatic report_mismatch(input string msg);
    $display("phcal_checker: %0t ns: %s", $time, msg);
    n_fail++;
  endtask

  // a/b to nearest, ties away from zero; b is never zero here
  function automatic longint div_nearest(input longint a, input longint b);
    bit     neg;
    longint ua;
    longint ub;
    longint q;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    q   = (2 * ua + ub) / (2 * ub);
    return neg ? -q : q;
  endfunction

  function automatic logic [PH_W-1:0] ph_from_sum(input logic [SUM_W-1:0] sum);
    longint n;
    longint s;
    longint mid_pt;
    longint num;
    longint den;
    longint ph;
    n      = SAMPLES_PER_READING;
    s      = longint'(sum);
    mid_pt = longint'(cal.cal7) * n;
    if (s <= mid_pt) begin
      num = (mid_pt - s) * PH_SPAN;
      den = (longint'(cal.cal7) - longint'(cal.cal4)) * n;
      if (den == 0) begin
        ph = (num == 0) ? PH_MID : 0;
      end else begin
        ph = PH_MID - div_nearest(num, den);
      end
    end else begin
      num = (s - mid_pt) * PH_SPAN;
      den = (longint'(cal.cal10) - longint'(cal.cal7)) * n;
      if (den == 0) begin
        ph = PH_MAX;
      end else begin
        ph = PH_MID + div_nearest(num, den);
      end
    end
    if (ph < 0) ph = 0;
    if (ph > PH_MAX) ph = PH_MAX;
    return PH_W'(ph);
  endfunction

  always @(posedge clk) begin
    reading_t         want;
    logic [SUM_W-1:0] total;
    logic [PH_W-1:0]  ph;
    if (!rst_n) begin
      cal.cal4   = CAL4_RST;
      cal.cal7   = CAL7_RST;
      cal.cal10  = CAL10_RST;
      cal.hi_lim = HI_LIM_RST;
      cal.lo_lim = LO_LIM_RST;
      group_sum  = '0;
      group_cnt  = '0;
      relay      = 1'b0;
      reading_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_CAL4:   cal.cal4   = pwdata[CAL_W-1:0];
          REG_CAL7:   cal.cal7   = pwdata[CAL_W-1:0];
          REG_CAL10:  cal.cal10  = pwdata[CAL_W-1:0];
          REG_HI_LIM: cal.hi_lim = pwdata[LIM_W-1:0];
          REG_LO_LIM: cal.lo_lim = pwdata[LIM_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (reading_q.size() == 0) begin
          report_mismatch($sformatf("unexpected reading ph=%0d ionizer=%0b",
                                    out_ph, out_ion));
        end else begin
          want = reading_q.pop_front();
          if (out_ph !== want.ph || out_ion !== want.ion) begin
            report_mismatch($sformatf("reading ph=%0d ionizer=%0b, want ph=%0d ionizer=%0b",
                                      out_ph, out_ion, want.ph, want.ion));
          end
        end
      end
      if (in_valid && in_ready) begin
        total = group_sum + SUM_W'(in_sample);
        if (group_cnt == IDX_W'(SAMPLES_PER_READING - 1)) begin
          ph = ph_from_sum(total);
          if (ph > cal.hi_lim) begin
            relay = 1'b0;
          end else if (ph < cal.lo_lim) begin
            relay = 1'b1;
          end
          reading_q.push_back('{ph: ph, ion: relay});
          group_sum = '0;
          group_cnt = '0;
        end else begin
          group_sum = total;
          group_cnt = group_cnt + IDX_W'(1);
        end
      end
    end
    pending    <= reading_q.size();
    fail_count <= n_fail;
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives ADC sample groups and calibration writes into the pH block under a
// sequence of calibration setups and handshake idle patterns; a checker
// beside the block predicts and compares every reading.
// ----------------------------------------------------------------------------
module tb_top import phcal_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     ADC_MAX          = 2**ADC_BITS - 1;
  localparam int     LIM_MAX          = 2**LIM_W - 1;
  localparam int     GROUPS_PER_PHASE = 22;
  localparam int     PAUSE_GROUP      = 7;
  // margin beyond the time a conversion holds the input off
  localparam int     DRAIN_CYCLES     = DVD_W + 20;
  localparam longint TIMEOUT_NS       = 10_000_000;

  typedef enum int {
    PAT_UNIFORM,
    PAT_FLAT,
    PAT_JITTER,
    PAT_RAILS
  } pattern_t;

  typedef enum int {
    SETUP_ORDERED,
    SETUP_FLAT_LOWER,
    SETUP_FLAT_UPPER,
    SETUP_REVERSED,
    SETUP_FULL_SCALE,
    SETUP_CROSSED,
    SETUP_EQUAL_LIMITS,
    SETUP_RANDOM,
    SETUP_DEFAULTS,
    SETUP_COUNT
  } cal_setup_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int send_idle_pct;
  int recv_stall_pct;
  int fail_count;
  int pending;

  phcal_in_if  in_ch ();
  phcal_out_if out_ch ();

  ph_average_calibrate_hysteresis_top u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  phcal_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_sample  (in_ch.adc_sample),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_ph     (out_ch.ph_hundredths),
    .out_ion    (out_ch.ionizer_on),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(TIMEOUT_NS);
    $display("tb_top: errors");
    $finish;
  end

  // Result side: stall ready at the rate the current phase asks for.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // One APB write: setup cycle, access cycle, then wait for pready and drop
  // the bus before returning, so back-to-back writes never re-raise psel in the
  // step that lowers it.
  task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Write all five registers with random junk above the field width, then
  // hit every unmapped index; those writes come last so an aliasing decode
  // would corrupt a live register and show up in the readings.
  task automatic program_cal(input logic [CAL_W-1:0] c4, input logic [CAL_W-1:0] c7,
                             input logic [CAL_W-1:0] c10, input logic [LIM_W-1:0] hi,
                             input logic [LIM_W-1:0] lo);
    logic [DATA_W-1:0] data;
    data = $urandom; data[CAL_W-1:0] = c4;  apb_write(REG_CAL4, data);
    data = $urandom; data[CAL_W-1:0] = c7;  apb_write(REG_CAL7, data);
    data = $urandom; data[CAL_W-1:0] = c10; apb_write(REG_CAL10, data);
    data = $urandom; data[LIM_W-1:0] = hi;  apb_write(REG_HI_LIM, data);
    data = $urandom; data[LIM_W-1:0] = lo;  apb_write(REG_LO_LIM, data);
    for (int i = NUM_REGS; i < 2**REG_IDX_W; i++) begin
      apb_write(REG_IDX_W'(i), $urandom);
    end
  endtask

  // Offer one sample, inserting random idle cycles first, and hold it until
  // the transfer. Valid stays high afterward so the next sample can follow
  // with no bubble.
  task automatic push_sample(input logic [ADC_BITS-1:0] v);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_ch.valid      <= 1'b0;
      in_ch.adc_sample <= ADC_BITS'($urandom);
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.adc_sample <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic push_group(input pattern_t pat, input int level);
    int v;
    for (int i = 0; i < SAMPLES_PER_READING; i++) begin
      case (pat)
        PAT_UNIFORM: v = $urandom_range(ADC_MAX, 0);
        PAT_FLAT:    v = level;
        PAT_JITTER:  v = level + int'($urandom_range(6, 0)) - 3;
        default:     v = $urandom_range(1, 0) ? ADC_MAX : 0;
      endcase
      if (v < 0) v = 0;
      if (v > ADC_MAX) v = ADC_MAX;
      push_sample(ADC_BITS'(v));
    end
  endtask

  // Drop valid and hold off until every predicted reading has arrived.
  // Always wait on the clock before testing: the checker's count is registered.
  task automatic wait_readings;
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int         a4;
    int         a7;
    int         a10;
    int         hi;
    int         lo;
    int         level;
    pattern_t   pat;
    cal_setup_t setup;
    idle_mode_t idle;

    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.adc_sample = '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: both rails through the reset calibration, no idling.
    push_group(PAT_FLAT, 0);
    push_group(PAT_FLAT, ADC_MAX);
    wait_readings();
    repeat (DRAIN_CYCLES) @(posedge clk);

    for (int p = 0; p < SETUP_COUNT; p++) begin
      setup = cal_setup_t'(p);
      idle  = idle_mode_t'(p % 4);

      // Pick the calibration for this phase.
      case (setup)
        SETUP_ORDERED: begin
          a7  = $urandom_range(700, 300);
          a4  = a7 - int'($urandom_range(250, 50));
          a10 = a7 + int'($urandom_range(250, 50));
          lo  = $urandom_range(720, 600);
          hi  = lo + int'($urandom_range(100, 0));
        end
        SETUP_FLAT_LOWER: begin
          // pH 4 and pH 7 points coincide: lower side has no slope
          a7  = $urandom_range(700, 300);
          a4  = a7;
          a10 = a7 + int'($urandom_range(300, 1));
          lo  = $urandom_range(700, 300);
          hi  = lo + int'($urandom_range(300, 0));
        end
        SETUP_FLAT_UPPER: begin
          // pH 7 and pH 10 points coincide: upper side pins to full scale
          a7  = $urandom_range(700, 300);
          a4  = a7 - int'($urandom_range(300, 1));
          a10 = a7;
          lo  = $urandom_range(900, 500);
          hi  = lo + int'($urandom_range(500, 0));
        end
        SETUP_REVERSED: begin
          a7  = $urandom_range(700, 300);
          a4  = a7 + int'($urandom_range(300, 1));
          a10 = a7 - int'($urandom_range(300, 1));
          lo  = $urandom_range(700, 400);
          hi  = lo + int'($urandom_range(200, 0));
        end
        SETUP_FULL_SCALE: begin
          // widest span, limits at the register rails so the relay holds
          a4  = 0;
          a7  = $urandom_range(600, 400);
          a10 = ADC_MAX;
          lo  = 0;
          hi  = LIM_MAX;
        end
        SETUP_CROSSED: begin
          // low limit above the high one, calibration at the count rails
          a4  = ADC_MAX;
          a7  = ADC_MAX;
          a10 = 0;
          lo  = LIM_MAX;
          hi  = 0;
        end
        SETUP_EQUAL_LIMITS: begin
          a7  = $urandom_range(600, 400);
          a4  = a7 - int'($urandom_range(200, 20));
          a10 = a7 + int'($urandom_range(200, 20));
          lo  = $urandom_range(PH_MAX, 0);
          hi  = lo;
        end
        SETUP_DEFAULTS: begin
          a4  = 358;
          a7  = 522;
          a10 = 666;
          hi  = 760;
          lo  = 720;
        end
        default: begin
          a4  = $urandom_range(ADC_MAX, 0);
          a7  = $urandom_range(ADC_MAX, 0);
          a10 = $urandom_range(ADC_MAX, 0);
          lo  = $urandom_range(LIM_MAX, 0);
          hi  = $urandom_range(LIM_MAX, 0);
        end
      endcase
      program_cal(CAL_W'(a4), CAL_W'(a7), CAL_W'(a10), LIM_W'(hi), LIM_W'(lo));

      // Set the idle pattern for both sides.
      case (idle)
        IDLE_NONE: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        IDLE_SEND: begin send_idle_pct <= 50; recv_stall_pct <= 0;  end
        IDLE_RECV: begin send_idle_pct <= 0;  recv_stall_pct <= 50; end
        default:   begin send_idle_pct <= 12; recv_stall_pct <= 12; end
      endcase

      for (int g = 0; g < GROUPS_PER_PHASE; g++) begin
        // Open each phase right at the pH 7 point and one count either side:
        // exercises the side split, the zero numerator and the nearest ties.
        if (g < 3) begin
          level = a7 + ((g == 1) ? 1 : 0) - ((g == 2) ? 1 : 0);
          if (level < 0) level = 0;
          if (level > ADC_MAX) level = ADC_MAX;
          push_group(PAT_FLAT, level);
        end else begin
          pat = pattern_t'($urandom_range(PAT_RAILS, PAT_UNIFORM));
          case ($urandom_range(3, 0))
            0:       level = a4;
            1:       level = a7;
            2:       level = a10;
            default: level = $urandom_range(ADC_MAX, 0);
          endcase
          level = level + int'($urandom_range(8, 0)) - 4;
          push_group(pat, level);
        end
        // Starve the block until it has caught up, once per phase and
        // now and then at random.
        if (g == PAUSE_GROUP || $urandom_range(39, 0) == 0) begin
          wait_readings();
        end
      end

      // Drain before touching the registers again.
      wait_readings();
      repeat (DRAIN_CYCLES) @(posedge clk);
    end

    // Final drain with the receiver free-running, then the verdict.
    recv_stall_pct <= 0;
    wait_readings();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== ph_average_calibrate_hysteresis_top.f =====
rtl/phcal_pkg.sv
rtl/phcal_if.sv
rtl/phcal_regs.sv
rtl/phcal_accum.sv
rtl/phcal_div.sv
rtl/phcal_conv.sv
rtl/ph_average_calibrate_hysteresis_top.sv
tb/phcal_checker.sv
tb/tb_top.sv
